// File: rtl/core/lirs_pkg.sv
// shared types and constants of the linear interpolation resampler
`default_nettype none

package lirs_pkg;

    // fixed widths of the data path
    localparam int SAMPLE_W = 16;
    localparam int INC_W    = 32;
    localparam int POS_W    = 33;

    // sample pair queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // configuration register indexes
    localparam logic REG_PHASE_INC = 1'b0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // one interval to interpolate across
    typedef struct packed {
        sample_t prev;
        sample_t cur;
    } pair_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

endpackage

`default_nettype wire

// File: rtl/core/lirs_front.sv
// input side: takes samples, keeps the stored one, forms interval pairs
`default_nettype none

module lirs_front
    import lirs_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire sample_t s_in_sample,
    input  wire q_stat_t q_stat,
    output logic         q_push,
    output pair_t        q_wdata
);

    logic    have_prev_reg;
    sample_t prev_reg;
    logic    accept;

    // the first sample is only stored, so it never needs queue room
    assign s_ready = !have_prev_reg || !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && have_prev_reg;

    assign q_wdata.prev = prev_reg;
    assign q_wdata.cur  = s_in_sample;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
        end else if (accept) begin
            have_prev_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else if (accept) begin
            prev_reg <= s_in_sample;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/lirs_queue.sv
// small fifo of sample pairs between the front and back sides
`default_nettype none

module lirs_queue
    import lirs_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire pair_t wdata,
    input  wire logic  pop,
    output pair_t      rdata,
    output q_stat_t    stat
);

    pair_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg;
    logic [Q_AW-1:0]  rd_ptr_reg;
    logic [Q_AW:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/lirs_back.sv
// output side: walks the output position across each interval and blends
`default_nettype none

module lirs_back
    import lirs_pkg::*;
#(
    parameter int FRAC_WIDTH  = 16,
    parameter int MAX_OUTPUTS = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [INC_W-1:0]  phase_inc,
    input  wire pair_t             q_rdata,
    input  wire q_stat_t           q_stat,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sample_t                m_out_sample,
    output logic                   m_last_of_run
);

    localparam int CNT_W = $clog2(MAX_OUTPUTS);
    localparam int PW    = FRAC_WIDTH + 18;
    localparam int NW    = FRAC_WIDTH + 19;
    localparam logic [POS_W-1:0] ONE_STEP = POS_W'(1) << FRAC_WIDTH;

    back_state_t state_reg, state_next;

    logic [POS_W-1:0] offset_reg;
    logic [CNT_W-1:0] cnt_reg;
    sample_t          a_reg;
    sample_t          b_reg;

    logic             s1_valid_reg;
    logic             s1_last_reg;
    sample_t          s1_a_reg;
    logic signed [PW-1:0] s1_prod_reg;

    logic             out_valid_reg;
    logic             out_last_reg;
    sample_t          out_sample_reg;

    logic             adv_out;
    logic             adv_s1;
    logic             fire;
    logic             in_step;
    logic             next_in;
    logic             cap;
    logic             run_last;
    logic [POS_W-1:0] sum_off;
    logic [POS_W-1:0] final_off;
    logic signed [SAMPLE_W:0] diff;
    logic signed [PW-1:0]     prod;
    logic signed [NW-1:0]     num;
    logic [SAMPLE_W-1:0]      quot;

    assign adv_out = !out_valid_reg || m_ready;
    assign adv_s1  = !s1_valid_reg || adv_out;

    // position tests and the next step
    assign in_step   = (offset_reg[POS_W-1:FRAC_WIDTH] == '0);
    assign sum_off   = offset_reg + {1'b0, phase_inc};
    assign next_in   = (sum_off[POS_W-1:FRAC_WIDTH] == '0);
    assign cap       = (cnt_reg == CNT_W'(MAX_OUTPUTS - 1));
    assign run_last  = !next_in || cap;
    assign final_off = (next_in ? ONE_STEP : sum_off) - ONE_STEP;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty && in_step) begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN: begin
                if (fire && run_last) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        q_pop = 1'b0;
        fire  = 1'b0;
        case (state_reg)
            BK_IDLE: q_pop = !q_stat.empty;
            BK_RUN:  fire  = adv_s1;
            default: begin
                q_pop = 1'b0;
                fire  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            cnt_reg    <= '0;
        end else if (q_pop) begin
            if (!in_step) begin
                offset_reg <= offset_reg - ONE_STEP;
            end
            cnt_reg <= '0;
        end else if (fire) begin
            offset_reg <= run_last ? final_off : sum_off;
            cnt_reg    <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            a_reg <= q_rdata.prev;
            b_reg <= q_rdata.cur;
        end
    end

    // prev + (cur - prev) * f, scaled by one step
    assign diff = {b_reg[SAMPLE_W-1], b_reg} - {a_reg[SAMPLE_W-1], a_reg};
    assign prod = diff * $signed({1'b0, offset_reg[FRAC_WIDTH-1:0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv_s1) begin
            s1_valid_reg <= fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_s1 && fire) begin
            s1_prod_reg <= prod;
            s1_a_reg    <= a_reg;
            s1_last_reg <= run_last;
        end
    end

    // divide by one step, truncating toward zero
    assign num  = $signed({{3{s1_a_reg[SAMPLE_W-1]}}, s1_a_reg, {FRAC_WIDTH{1'b0}}})
                + $signed({s1_prod_reg[PW-1], s1_prod_reg});
    assign quot = num[FRAC_WIDTH +: SAMPLE_W]
                + {{(SAMPLE_W-1){1'b0}}, (num[NW-1] && (|num[FRAC_WIDTH-1:0]))};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv_out) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out && s1_valid_reg) begin
            out_sample_reg <= sample_t'(quot);
            out_last_reg   <= s1_last_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_out_sample  = out_sample_reg;
    assign m_last_of_run = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/linear_interp_resampler_top.sv
// top level of the linear interpolation resampler with its register port
`default_nettype none
//
// resamples a stream of signed 16-bit samples by linear interpolation
// - s_ channel: one input sample per transaction (s_valid / s_ready)
// - m_ channel: interpolated samples, m_last_of_run marks the last output
//   caused by one input sample (m_valid / m_ready)
// - apb port: phase_increment at byte address 0, step of output position
//   per output with FRAC_WIDTH fraction bits; write it only while idle
// - the first sample after reset is only stored and gives no output
// - an input sample enters a 4-deep pair queue; the back side pops a pair
//   in its idle state, then emits one output per cycle while the receiver
//   keeps up, through a multiply stage and an output register; an input
//   with no output in its interval only takes the pop
// - with the back side idle, an input's pair passes the queue, the pop,
//   the multiply stage and the output register before m_valid rises
// - at most MAX_OUTPUTS outputs per input; the rest of the run is dropped
// - reset clears the stored sample, the position and the pair queue, and
//   sets phase_increment to 65536, one step at the default FRAC_WIDTH of 16
// - when the receiver stalls, the output register holds and the queue
//   fills; s_ready then drops until a pair is taken
//
module linear_interp_resampler_top
    import lirs_pkg::*;
#(
    parameter int FRAC_WIDTH  = 16,
    parameter int MAX_OUTPUTS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input samples
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire sample_t     s_in_sample,
    // output samples
    output logic             m_valid,
    input  wire logic        m_ready,
    output sample_t          m_out_sample,
    output logic             m_last_of_run,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [INC_W-1:0] INC_RESET = 32'd65536;

    logic [INC_W-1:0] phase_inc_reg;
    q_stat_t          q_stat;
    logic             q_push;
    logic             q_pop;
    pair_t            q_wdata;
    pair_t            q_rdata;
    logic             reg_wr;

    // register access, one register, word index in paddr[2]
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_PHASE_INC) ? phase_inc_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_inc_reg <= INC_RESET;
        end else if (reg_wr && (paddr[2] == REG_PHASE_INC)) begin
            phase_inc_reg <= pwdata;
        end
    end

    // front: accepts samples and pairs them with the stored one
    lirs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_sample (s_in_sample),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    // decouples the input side from output stalls
    lirs_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    // back: position walk, blend and output register
    lirs_back #(
        .FRAC_WIDTH  (FRAC_WIDTH),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .phase_inc     (phase_inc_reg),
        .q_rdata       (q_rdata),
        .q_stat        (q_stat),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_sample  (m_out_sample),
        .m_last_of_run (m_last_of_run)
    );

endmodule

`default_nettype wire

// File: rtl/core/lirs_checker.sv
// port checks of the resampler top level and their bind
`default_nettype none

module lirs_checker
    import lirs_pkg::*;
(
    input wire logic    aclk,
    input wire logic    aresetn,
    input wire logic    s_ready,
    input wire logic    m_valid,
    input wire logic    m_ready,
    input wire sample_t m_out_sample,
    input wire logic    m_last_of_run
);

    // a stalled transaction holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_sample)
                                && $stable(m_last_of_run))
        else $error("output changed while stalled");

    // reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    // the first sample after reset is always taken
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

endmodule

bind linear_interp_resampler_top lirs_checker u_lirs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_sample  (m_out_sample),
    .m_last_of_run (m_last_of_run)
);

`default_nettype wire
